// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands. Sites must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/clsrng_pkg.sv -----
// ----------------------------------------------------------------------------
// clsrng_pkg
// Shared types and constants of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clsrng_pkg;

    localparam int VAL_W  = 31;
    localparam int PROD_W = 47;

    localparam logic [VAL_W-1:0] MOD_ONE       = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD_TWO       = 31'd2147483399;
    localparam logic [VAL_W-1:0] TOP_OUT       = 31'd2147483562;
    localparam logic [15:0]      MUL_ONE       = 16'd40014;
    localparam logic [15:0]      MUL_TWO       = 16'd40692;
    // 2^31 mod each modulus, used to fold the high product bits back in
    localparam logic [7:0]       FOLD_ONE      = 8'd85;
    localparam logic [7:0]       FOLD_TWO      = 8'd249;
    localparam logic [VAL_W-1:0] GEN_ONE_RESET = 31'd1;
    localparam logic [VAL_W-1:0] GEN_TWO_RESET = 31'd123456789;

    // request kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] seed_value;
    } clsrng_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
    } clsrng_rsp_t;

    typedef struct packed {
        logic load_seed;
        logic mul_en;
        logic fold_en;
        logic upd_one;
        logic upd_two;
        logic warm_wr;
        logic rd_en;
        logic finish;
    } clsrng_cmd_t;

    typedef struct packed {
        logic out_free;
    } clsrng_stat_t;

endpackage

`default_nettype wire

// ----- hdl/clsrng_stream_if.sv -----
// ----------------------------------------------------------------------------
// clsrng_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface clsrng_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/clsrng_ctrl.sv -----
// ----------------------------------------------------------------------------
// clsrng_ctrl
// Sequencer: reseed warm-up loop and the four-step draw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clsrng_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    input  wire logic                         req_kind,
    output logic                              req_ready,
    output clsrng_pkg::clsrng_cmd_t           cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]    warm_idx,
    input  wire clsrng_pkg::clsrng_stat_t     stat
);
    import clsrng_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 8);
    localparam logic [CW-1:0] WARM_LAST = CW'(TABLE_DEPTH + 7);
    localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_WFOLD,
        S_WRED,
        S_DMUL,
        S_DFOLD,
        S_DRED,
        S_DOUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_kind == KIND_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = WARM_LAST;
                        state_next    = S_WMUL;
                    end
                    else
                    begin
                        cmd.mul_en = 1'b1;
                        state_next = S_DFOLD;
                    end
                end
            end
            S_WMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_WFOLD;
            end
            S_WFOLD:
            begin
                cmd.fold_en = 1'b1;
                state_next  = S_WRED;
            end
            S_WRED:
            begin
                cmd.upd_one = 1'b1;
                cmd.warm_wr = (cnt_reg < DEPTH_C);
                if (cnt_reg == '0)
                begin
                    state_next = S_DMUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_WMUL;
                end
            end
            S_DMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_DFOLD;
            end
            S_DFOLD:
            begin
                cmd.fold_en = 1'b1;
                state_next  = S_DRED;
            end
            S_DRED:
            begin
                cmd.upd_one = 1'b1;
                cmd.upd_two = 1'b1;
                cmd.rd_en   = 1'b1;
                state_next  = S_DOUT;
            end
            S_DOUT:
            begin
                // hold until the result register can take the value
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready = ready_reg;
    assign warm_idx  = cnt_reg[AW-1:0];

    `ASSERT_NEXT(a_seed_starts_warm, req_valid && req_ready && req_kind == KIND_RESEED,
        state_reg == S_WMUL && cnt_reg == WARM_LAST, "reseed did not start warm-up")
    `ASSERT_NEXT(a_warm_ends_in_draw, state_reg == S_WRED && cnt_reg == '0,
        state_reg == S_DMUL, "warm-up did not hand over to the draw")
    `ASSERT_NEXT(a_finish_to_idle, cmd.finish,
        req_ready && state_reg == S_IDLE, "not ready after a finished draw")

endmodule

`default_nettype wire

// ----- hdl/clsrng_dp.sv -----
// ----------------------------------------------------------------------------
// clsrng_dp
// Generator registers, constant-modulus multipliers, slot divider,
// shuffle table and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clsrng_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire clsrng_pkg::clsrng_cmd_t              cmd,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]       warm_idx,
    input  wire logic [clsrng_pkg::VAL_W-1:0]         seed_value,
    output clsrng_pkg::clsrng_stat_t                  stat,
    output logic                                      out_valid,
    output logic [clsrng_pkg::VAL_W-1:0]              out_value,
    input  wire logic                                 out_ready
);
    import clsrng_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QW = AW + 1;
    localparam int unsigned SLOT_DIV = 1 + 32'd2147483562 / TABLE_DEPTH;
    // floor(2^31 / SLOT_DIV): estimate is exact or one short
    localparam int unsigned RECIP    = 32'h8000_0000 / SLOT_DIV;
    localparam logic [QW-1:0]   RECIP_Q  = QW'(RECIP);
    localparam logic [31:0]     DIV_C    = 32'(SLOT_DIV);
    localparam logic [QW-1:0]   DEPTH_Q  = QW'(TABLE_DEPTH);
    localparam logic [AW-1:0]   LAST_IDX = AW'(TABLE_DEPTH - 1);

    logic [VAL_W-1:0]  gen_one_reg, gen_one_next;
    logic [VAL_W-1:0]  gen_two_reg, gen_two_next;
    logic [VAL_W-1:0]  last_out_reg, last_out_next;
    logic [PROD_W-1:0] prod_one_reg, prod_one_next;
    logic [PROD_W-1:0] prod_two_reg, prod_two_next;
    logic [31:0]       fold_one_reg, fold_one_next;
    logic [31:0]       fold_two_reg, fold_two_next;
    logic [QW-1:0]     q_est_reg, q_est_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [VAL_W-1:0]  rd_raw_reg;
    logic              rd_vld_reg;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic [TABLE_DEPTH-1:0] tbl_vld_reg;

    logic [VAL_W-1:0]  table_mem [TABLE_DEPTH];

    logic [VAL_W-1:0]     seed_eff;
    logic [VAL_W+QW-1:0]  est_prod;
    logic [31:0]          q_times_div;
    logic [31:0]          div_rem;
    logic [QW-1:0]        q_fix;
    logic [31:0]          red_one_w, red_two_w;
    logic [VAL_W-1:0]     red_one, red_two;
    logic [VAL_W-1:0]     tbl_val;
    logic [31:0]          draw_w;
    logic [VAL_W-1:0]     draw_val;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VAL_W-1:0]     wr_data;

    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        seed_eff = (seed_value == '0) ? GEN_ONE_RESET : seed_value;

        // slot = last_out / SLOT_DIV via reciprocal and one correction
        est_prod    = (VAL_W+QW)'(last_out_reg) * (VAL_W+QW)'(RECIP_Q);
        q_times_div = 32'(q_est_reg) * DIV_C;
        div_rem     = 32'(last_out_reg) - q_times_div;
        q_fix       = (div_rem >= DIV_C) ? q_est_reg + 1'b1 : q_est_reg;

        // final conditional subtract of the folded product
        red_one_w = (fold_one_reg >= 32'(MOD_ONE)) ? fold_one_reg - 32'(MOD_ONE)
                                                   : fold_one_reg;
        red_two_w = (fold_two_reg >= 32'(MOD_TWO)) ? fold_two_reg - 32'(MOD_TWO)
                                                   : fold_two_reg;
        red_one   = red_one_w[VAL_W-1:0];
        red_two   = red_two_w[VAL_W-1:0];

        tbl_val  = rd_vld_reg ? rd_raw_reg : '0;
        draw_w   = (tbl_val > gen_two_reg)
                 ? 32'(tbl_val) - 32'(gen_two_reg)
                 : 32'(tbl_val) + 32'(TOP_OUT) - 32'(gen_two_reg);
        draw_val = draw_w[VAL_W-1:0];

        gen_one_next   = gen_one_reg;
        gen_two_next   = gen_two_reg;
        last_out_next  = last_out_reg;
        prod_one_next  = prod_one_reg;
        prod_two_next  = prod_two_reg;
        fold_one_next  = fold_one_reg;
        fold_two_next  = fold_two_reg;
        q_est_next     = q_est_reg;
        slot_next      = slot_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load_seed)
        begin
            gen_one_next = seed_eff;
            gen_two_next = seed_eff;
        end
        if (cmd.mul_en)
        begin
            prod_one_next = PROD_W'(gen_one_reg) * PROD_W'(MUL_ONE);
            prod_two_next = PROD_W'(gen_two_reg) * PROD_W'(MUL_TWO);
            q_est_next    = est_prod[VAL_W+QW-1:VAL_W];
        end
        if (cmd.fold_en)
        begin
            fold_one_next = 32'(prod_one_reg[PROD_W-1:VAL_W]) * 32'(FOLD_ONE)
                          + 32'(prod_one_reg[VAL_W-1:0]);
            fold_two_next = 32'(prod_two_reg[PROD_W-1:VAL_W]) * 32'(FOLD_TWO)
                          + 32'(prod_two_reg[VAL_W-1:0]);
            slot_next     = (q_fix >= DEPTH_Q) ? LAST_IDX : q_fix[AW-1:0];
        end
        if (cmd.upd_one)
        begin
            gen_one_next = red_one;
        end
        if (cmd.upd_two)
        begin
            gen_two_next = red_two;
        end
        // the final warm-up write lands in slot 0 and becomes last_out
        if (cmd.warm_wr)
        begin
            last_out_next = red_one;
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            last_out_next  = draw_val;
            out_value_next = draw_val;
            out_valid_next = 1'b1;
        end

        wr_en   = cmd.warm_wr || cmd.finish;
        wr_addr = cmd.warm_wr ? warm_idx : slot_reg;
        wr_data = cmd.warm_wr ? red_one : gen_one_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_one_reg   <= GEN_ONE_RESET;
            gen_two_reg   <= GEN_TWO_RESET;
            last_out_reg  <= '0;
            out_valid_reg <= 1'b0;
            tbl_vld_reg   <= '0;
        end
        else
        begin
            gen_one_reg   <= gen_one_next;
            gen_two_reg   <= gen_two_next;
            last_out_reg  <= last_out_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                tbl_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_one_reg  <= prod_one_next;
        prod_two_reg  <= prod_two_next;
        fold_one_reg  <= fold_one_next;
        fold_two_reg  <= fold_two_next;
        q_est_reg     <= q_est_next;
        slot_reg      <= slot_next;
        out_value_reg <= out_value_next;
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_raw_reg <= table_mem[slot_reg];
            rd_vld_reg <= tbl_vld_reg[slot_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    `ASSERT_IMPLY(a_out_range, out_valid_reg,
        out_value_reg != '0 && out_value_reg <= TOP_OUT, "result out of range")
    `ASSERT_IMPLY(a_out_from_finish, $rose(out_valid_reg),
        $past(cmd.finish), "result appeared without a finished draw")
    `ASSERT_NEXT(a_gen_one_reduced, cmd.upd_one,
        gen_one_reg < MOD_ONE, "generator one left unreduced")

endmodule

`default_nettype wire

// ----- hdl/combined_lcg_shuffle_rng_unit.sv -----
// Draw request: accepted in the idle cycle; the result register is loaded after
// the multiply-fold-reduce sequence of the constant-modulus generators and the
// table read-modify-write, held back while the previous result is not taken.
// Reseed request: result loaded after the serial warm-up steps and one draw.
// A new request is accepted only after the previous one has finished.
// Reset: generators 1 and 123456789, previous output 0, table reads as zero.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Two combined multiplicative congruential generators with a shuffle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    clsrng_stream_if.sink     req,
    clsrng_stream_if.source   rsp
);
    import clsrng_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    clsrng_cmd_t   cmd;
    clsrng_stat_t  stat;
    logic [AW-1:0] warm_idx;
    logic          ready_w;
    logic          out_valid_w;
    logic [VAL_W-1:0] out_value_w;

    clsrng_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.payload.kind),
        .req_ready (ready_w),
        .cmd       (cmd),
        .warm_idx  (warm_idx),
        .stat      (stat)
    );

    clsrng_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .warm_idx   (warm_idx),
        .seed_value (req.payload.seed_value),
        .stat       (stat),
        .out_valid  (out_valid_w),
        .out_value  (out_value_w),
        .out_ready  (rsp.ready)
    );

    assign req.ready         = ready_w;
    assign rsp.valid         = out_valid_w;
    assign rsp.payload.value = out_value_w;

endmodule

`default_nettype wire
